FILE: sv/multi_frame_pixel_averager_defines.svh
// ----------------------------------------------------------------------------
// Multi-frame pixel averager assertion macros
// Assertion forms used by the averager back end.
// ----------------------------------------------------------------------------
`ifndef MULTI_FRAME_PIXEL_AVERAGER_DEFINES_SVH
`define MULTI_FRAME_PIXEL_AVERAGER_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define MFPA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define MFPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/mfpa_pkg.sv
// ----------------------------------------------------------------------------
// Multi-frame pixel averager package
// Widths, codes and item types shared by the averager modules.
// ----------------------------------------------------------------------------
package mfpa_pkg;

	localparam int MAX_PIXELS = 65536;
	localparam int MAX_FRAMES = 256;
	localparam int ADDR_W     = $clog2(MAX_PIXELS);
	localparam int FP_W       = ADDR_W + 1;
	localparam int CNT_W      = $clog2(MAX_FRAMES) + 1;
	localparam int PIX_W      = 8;
	localparam int SUM_W      = PIX_W + $clog2(MAX_FRAMES);
	localparam int STEP_W     = $clog2(SUM_W);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

	localparam logic OP_ACC  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic             operation;
		logic [PIX_W-1:0] pixel;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] average;
		logic             last;
		logic             too_few_frames;
	} out_item_t;

	typedef struct packed {
		logic              op;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  pixel;
		logic [CNT_W-1:0]  count;
		logic              last;
	} entry_t;

endpackage

FILE: sv/mfpa_front.sv
// ----------------------------------------------------------------------------
// Averager front end
// Tracks position and frame count, drops surplus frames, queues work.
// ----------------------------------------------------------------------------
module mfpa_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     pix_valid,
	output logic                     pix_stall,
	input  mfpa_pkg::in_item_t       pix_item,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [mfpa_pkg::FP_W-1:0] cfg_data,
	input  logic                     clearing,
	input  logic                     queue_full,
	output logic                     push,
	output mfpa_pkg::entry_t         push_entry
);

	logic [mfpa_pkg::FP_W-1:0]   frame_pixels_q;
	logic [mfpa_pkg::ADDR_W-1:0] position_q;
	logic [mfpa_pkg::CNT_W-1:0]  frame_count_q;
	logic [mfpa_pkg::FP_W-1:0]   eff_size;
	logic [mfpa_pkg::FP_W-1:0]   next_pos;
	logic                        wrap;
	logic                        accept;
	logic                        drop;

	assign cfg_ready = 1'b1;
	assign pix_stall = clearing | queue_full;
	assign accept    = pix_valid & ~pix_stall;

	always_comb begin
		if (frame_pixels_q == '0) begin
			eff_size = mfpa_pkg::FP_W'(1);
		end else if (frame_pixels_q > mfpa_pkg::FP_W'(mfpa_pkg::MAX_PIXELS)) begin
			eff_size = mfpa_pkg::FP_W'(mfpa_pkg::MAX_PIXELS);
		end else begin
			eff_size = frame_pixels_q;
		end
	end

	assign next_pos = {1'b0, position_q} + mfpa_pkg::FP_W'(1);
	assign wrap     = next_pos >= eff_size;
	// Full frame budget: ignore further accumulate items entirely
	assign drop     = (pix_item.operation == mfpa_pkg::OP_ACC) &&
		(frame_count_q >= mfpa_pkg::CNT_W'(mfpa_pkg::MAX_FRAMES));
	assign push     = accept & ~drop;

	always_comb begin
		push_entry.op    = pix_item.operation;
		push_entry.addr  = position_q;
		push_entry.pixel = pix_item.pixel;
		push_entry.count = frame_count_q;
		push_entry.last  = wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pixels_q <= mfpa_pkg::FP_W'(mfpa_pkg::MAX_PIXELS);
		end else if (cfg_valid && cfg_ready) begin
			frame_pixels_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q    <= '0;
			frame_count_q <= '0;
		end else if (push) begin
			position_q <= wrap ? '0 : next_pos[mfpa_pkg::ADDR_W-1:0];
			if (wrap) begin
				if (pix_item.operation == mfpa_pkg::OP_ACC) begin
					frame_count_q <= frame_count_q + mfpa_pkg::CNT_W'(1);
				end else begin
					frame_count_q <= '0;
				end
			end
		end
	end

endmodule

FILE: sv/mfpa_queue.sv
// ----------------------------------------------------------------------------
// Averager work queue
// Short FIFO between the front end and the memory back end.
// ----------------------------------------------------------------------------
module mfpa_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mfpa_pkg::entry_t push_entry,
	input  logic             pop,
	output mfpa_pkg::entry_t head,
	output logic             empty,
	output logic             full
);

	mfpa_pkg::entry_t              slots_q [mfpa_pkg::QUEUE_DEPTH];
	logic [mfpa_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [mfpa_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [mfpa_pkg::QPTR_W:0]     fill_q;

	assign empty = fill_q == '0;
	assign full  = fill_q == (mfpa_pkg::QPTR_W+1)'(mfpa_pkg::QUEUE_DEPTH);
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + mfpa_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + mfpa_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (mfpa_pkg::QPTR_W+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (mfpa_pkg::QPTR_W+1)'(1);
			end
		end
	end

endmodule

FILE: sv/mfpa_div.sv
// ----------------------------------------------------------------------------
// Averager divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mfpa_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [mfpa_pkg::SUM_W-1:0] dividend,
	input  logic [mfpa_pkg::CNT_W-1:0] divisor,
	output logic                       done,
	output logic [mfpa_pkg::SUM_W-1:0] quot,
	output logic [mfpa_pkg::CNT_W-1:0] rem
);

	logic                        busy_q;
	logic                        done_q;
	logic [mfpa_pkg::STEP_W-1:0] step_q;
	logic [mfpa_pkg::SUM_W-1:0]  dvd_q;
	logic [mfpa_pkg::CNT_W-1:0]  rem_q;
	logic [mfpa_pkg::CNT_W-1:0]  dsr_q;
	logic [mfpa_pkg::CNT_W:0]    trial;
	logic [mfpa_pkg::CNT_W:0]    diff;
	logic                        ge;

	assign trial = {rem_q, dvd_q[mfpa_pkg::SUM_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	assign done = done_q;
	assign quot = dvd_q;
	assign rem  = rem_q;

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so it fits back
			rem_q <= ge ? diff[mfpa_pkg::CNT_W-1:0] : trial[mfpa_pkg::CNT_W-1:0];
			dvd_q <= {dvd_q[mfpa_pkg::SUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + mfpa_pkg::STEP_W'(1);
				if (step_q == mfpa_pkg::STEP_W'(mfpa_pkg::SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

FILE: sv/mfpa_back.sv
// ----------------------------------------------------------------------------
// Averager back end
// Sum memory, clear sweep, read-modify-write and rounded averages.
// ----------------------------------------------------------------------------
`include "multi_frame_pixel_averager_defines.svh"

module mfpa_back (
	input  logic             clk,
	input  logic             arst_n,
	input  mfpa_pkg::entry_t head,
	input  logic             empty,
	output logic             pop,
	output logic             clearing,
	output logic             res_valid,
	input  logic             res_stall,
	output mfpa_pkg::out_item_t res_item
);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_MODIFY = 3'd2;
	localparam logic [2:0] ST_DIV    = 3'd3;
	localparam logic [2:0] ST_OUT    = 3'd4;

	logic [mfpa_pkg::SUM_W-1:0]  mem [mfpa_pkg::MAX_PIXELS];
	logic [2:0]                  state_q;
	logic [mfpa_pkg::ADDR_W-1:0] clr_q;
	mfpa_pkg::entry_t            cur_q;
	logic [mfpa_pkg::SUM_W-1:0]  rd_data_q;
	logic [mfpa_pkg::PIX_W-1:0]  avg_q;
	logic                        res_valid_q;
	mfpa_pkg::out_item_t         res_item_q;

	logic                        mem_we;
	logic [mfpa_pkg::ADDR_W-1:0] mem_wa;
	logic [mfpa_pkg::SUM_W-1:0]  mem_wd;
	logic                        div_start;
	logic                        div_done;
	logic [mfpa_pkg::SUM_W-1:0]  div_quot;
	logic [mfpa_pkg::CNT_W-1:0]  div_rem;
	logic [mfpa_pkg::CNT_W:0]    twice_rem;
	logic                        round_up;
	logic [mfpa_pkg::SUM_W:0]    rounded;
	logic [mfpa_pkg::PIX_W-1:0]  avg_sat;
	logic                        load_out;

	assign clearing  = state_q == ST_CLEAR;
	assign pop       = (state_q == ST_IDLE) && !empty;
	assign div_start = (state_q == ST_MODIFY) && (cur_q.op == mfpa_pkg::OP_READ) &&
		(cur_q.count != '0);
	assign load_out  = (state_q == ST_OUT) && (!res_valid_q || !res_stall);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = cur_q.addr;
		mem_wd = '0;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
		end else if (state_q == ST_MODIFY) begin
			mem_we = 1'b1;
			// read clears the entry, accumulate adds the pixel
			if (cur_q.op == mfpa_pkg::OP_ACC) begin
				mem_wd = rd_data_q + mfpa_pkg::SUM_W'(cur_q.pixel);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (pop) begin
			rd_data_q <= mem[head.addr];
		end
	end

	mfpa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rd_data_q),
		.divisor  (cur_q.count),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// round half to even, then saturate to the pixel range
	assign twice_rem = {div_rem, 1'b0};
	assign round_up  = (twice_rem > {1'b0, cur_q.count}) ||
		((twice_rem == {1'b0, cur_q.count}) && div_quot[0]);
	assign rounded   = {1'b0, div_quot} + (mfpa_pkg::SUM_W+1)'(round_up);
	assign avg_sat   = (rounded > (mfpa_pkg::SUM_W+1)'(255)) ? '1 :
		rounded[mfpa_pkg::PIX_W-1:0];

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if ((state_q == ST_MODIFY) && !div_start) begin
			avg_q <= '0;
		end else if (div_done) begin
			avg_q <= avg_sat;
		end
		if (load_out) begin
			res_item_q.average        <= avg_q;
			res_item_q.last           <= cur_q.last;
			res_item_q.too_few_frames <= cur_q.count < mfpa_pkg::CNT_W'(2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + mfpa_pkg::ADDR_W'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_MODIFY;
					end
				end
				ST_MODIFY: begin
					if (cur_q.op == mfpa_pkg::OP_ACC) begin
						state_q <= ST_IDLE;
					end else if (div_start) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

	`MFPA_ASSERT_NOW(a_div_done_in_div, div_done, state_q == ST_DIV, "divider done outside DIV")
	`MFPA_ASSERT_NEXT(a_acc_returns_idle, (state_q == ST_MODIFY) && (cur_q.op == mfpa_pkg::OP_ACC), state_q == ST_IDLE, "accumulate did not finish")
	`MFPA_ASSERT_NOW(a_write_own_addr, mem_we && (state_q != ST_CLEAR), mem_wa == cur_q.addr, "write to foreign entry")

endmodule

FILE: sv/multi_frame_pixel_averager.sv
// ----------------------------------------------------------------------------
// Multi-frame pixel averager
// Per-pixel rounded average over several accumulated frames.
//
//   channel  handshake            payload
//   pix      pix_valid/pix_stall  in_item_t (operation, pixel)
//   res      res_valid/res_stall  out_item_t (average, last, too_few_frames)
//   cfg      cfg_valid/cfg_ready  frame_pixels, 17 bits
//
// Accumulate items read the sum memory in the back end, then write the new sum back.
// Read items go through the 16-step serial divider, while a read with no frames
// counted skips the divider and goes straight to the output register.
// After reset a sweep clears the 65536-entry sum memory, one entry per cycle;
// pix is stalled during the sweep. Config writes are always taken.
// A 4-entry queue lets pix run ahead of the back end; res has an output register.
// ----------------------------------------------------------------------------
module multi_frame_pixel_averager (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      pix_valid,
	output logic                      pix_stall,
	input  mfpa_pkg::in_item_t        pix_item,
	output logic                      res_valid,
	input  logic                      res_stall,
	output mfpa_pkg::out_item_t       res_item,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [mfpa_pkg::FP_W-1:0] cfg_data
);

	logic             clearing;
	logic             queue_full;
	logic             queue_empty;
	logic             push;
	logic             pop;
	mfpa_pkg::entry_t push_entry;
	mfpa_pkg::entry_t head;

	mfpa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pix_item   (pix_item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.clearing   (clearing),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry)
	);

	mfpa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (queue_empty),
		.full       (queue_full)
	);

	mfpa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (queue_empty),
		.pop       (pop),
		.clearing  (clearing),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

endmodule

FILE: bench/multi_frame_pixel_averager_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-frame pixel averager testbench
// Drives accumulate and read items over several frame sizes. Each read result
// is checked against a typed expectation or a behavioral rounded-average model.
// A short table of directed rows comes first, then random frame sequences.
// ----------------------------------------------------------------------------
module multi_frame_pixel_averager_tb;

	localparam int IDLE_LIMIT = 200000;
	localparam int SETTLE     = 40;
	localparam int N_ITEMS    = 750;

	typedef struct {
		logic                si_cfg_unused;
		int                  size;
		mfpa_pkg::in_item_t  item;
		logic                typed;
		mfpa_pkg::out_item_t want;
	} row_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          pix_valid = 1'b0;
	logic                          pix_stall;
	mfpa_pkg::in_item_t            pix_item = '0;
	logic                          res_valid;
	logic                          res_stall = 1'b0;
	mfpa_pkg::out_item_t           res_item;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [mfpa_pkg::FP_W-1:0]     cfg_data = '0;

	// typed expectation carried alongside the item being offered
	logic                          row_typed = 1'b0;
	mfpa_pkg::out_item_t           row_want = '0;

	// model state
	int unsigned                   sums [mfpa_pkg::MAX_PIXELS];
	int unsigned                   pos;
	int unsigned                   frames;
	int unsigned                   size_reg;
	mfpa_pkg::out_item_t           avg_q [$];

	int                            errors = 0;
	int                            n_items = 0;
	int                            n_results = 0;
	int                            n_sizes = 0;
	int                            idle_cycles = 0;
	bit                            quiet = 1'b0;
	bit                            long_hold_req = 1'b0;

	multi_frame_pixel_averager dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_item  (pix_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int unsigned frame_len();
		int unsigned n;
		n = size_reg;
		if (n == 0) n = 1;
		if (n > mfpa_pkg::MAX_PIXELS) n = mfpa_pkg::MAX_PIXELS;
		return n;
	endfunction

	function automatic bit step_position();
		if (pos + 1 >= frame_len()) begin
			pos = 0;
			return 1'b1;
		end
		pos = pos + 1;
		return 1'b0;
	endfunction

	function automatic int unsigned round_avg(int unsigned sum, int unsigned cnt);
		int unsigned q;
		int unsigned r;
		if (cnt == 0) return 0;
		q = sum / cnt;
		r = sum % cnt;
		if (2 * longint'(r) > cnt || (2 * longint'(r) == cnt && q[0])) q++;
		if (q > 255) q = 255;
		return q;
	endfunction

	// update the model for one accepted item; queue the average it produces
	function automatic void fold_item(mfpa_pkg::in_item_t it, logic typed,
		mfpa_pkg::out_item_t want);
		mfpa_pkg::out_item_t o;
		if (it.operation == mfpa_pkg::OP_ACC) begin
			if (frames >= mfpa_pkg::MAX_FRAMES) return;
			sums[pos] += it.pixel;
			if (step_position()) frames++;
			return;
		end
		o.average = 8'(round_avg(sums[pos], frames));
		o.too_few_frames = frames < 2;
		sums[pos] = 0;
		o.last = step_position();
		if (o.last) frames = 0;
		avg_q = {avg_q, (typed ? want : o)};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (sums[i]) sums[i] = 0;
			pos = 0;
			frames = 0;
			size_reg = mfpa_pkg::MAX_PIXELS;
		end else begin
			if (cfg_valid && cfg_ready) size_reg = cfg_data;
			if (pix_valid && !pix_stall) fold_item(pix_item, row_typed, row_want);
			if (res_valid && !res_stall) begin
				n_results++;
				if (avg_q.size() == 0) begin
					$error("result with nothing expected: %p", res_item);
					errors++;
				end else begin
					mfpa_pkg::out_item_t e;
					e = avg_q.pop_front();
					if (res_item.average !== e.average) begin
						$error("average: expected %0d, got %0d", e.average, res_item.average);
						errors++;
					end
					if (res_item.last !== e.last) begin
						$error("last: expected %0b, got %0b", e.last, res_item.last);
						errors++;
					end
					if (res_item.too_few_frames !== e.too_few_frames) begin
						$error("too_few_frames: expected %0b, got %0b",
							e.too_few_frames, res_item.too_few_frames);
						errors++;
					end
				end
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((pix_valid && !pix_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("multi_frame_pixel_averager_tb: FAIL");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold on request
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				res_stall <= 1'b1;
				repeat (300) @(posedge clk);
				res_stall <= 1'b0;
				long_hold_req = 1'b0;
			end else if (!quiet && $urandom_range(7) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	task automatic offer(mfpa_pkg::in_item_t it, logic typed = 1'b0,
		mfpa_pkg::out_item_t want = '0);
		if (!quiet && $urandom_range(7) == 0) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pix_item  <= it;
		row_typed <= typed;
		row_want  <= want;
		do @(posedge clk); while (pix_stall);
		n_items++;
	endtask

	// hold the sender until every expected result is back
	task automatic drain();
		pix_valid <= 1'b0;
		@(posedge clk);
		wait (avg_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_size(int unsigned n);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= mfpa_pkg::FP_W'(n);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		n_sizes++;
	endtask

	function automatic mfpa_pkg::in_item_t mk(logic op, int unsigned p);
		mfpa_pkg::in_item_t it;
		it.operation = op;
		it.pixel = 8'(p);
		return it;
	endfunction

	function automatic mfpa_pkg::out_item_t res(int unsigned a, logic l, logic f);
		mfpa_pkg::out_item_t o;
		o.average = 8'(a);
		o.last = l;
		o.too_few_frames = f;
		return o;
	endfunction

	function automatic row_t acc(int unsigned p);
		return '{1'b0, 0, mk(mfpa_pkg::OP_ACC, p), 1'b0, '0};
	endfunction

	function automatic row_t rd(logic typed = 1'b0, mfpa_pkg::out_item_t want = '0);
		return '{1'b0, 0, mk(mfpa_pkg::OP_READ, 8'h5A), typed, want};
	endfunction

	function automatic row_t cfg(int unsigned n);
		return '{1'b1, n, '0, 1'b0, '0};
	endfunction

	row_t dir_rows [$];

	initial begin
		int unsigned sz;
		int unsigned nf;
		mfpa_pkg::in_item_t it;

		dir_rows = '{
			rd(1'b1, res(0, 0, 1)),            // no frames yet at reset size
			cfg(0),                            // zero size acts as one pixel
			rd(1'b1, res(0, 1, 1)),            // position past new size wraps
			acc(255), acc(255),
			rd(1'b1, res(255, 1, 0)),
			acc(0),
			rd(1'b1, res(0, 1, 1)),
			cfg(2),
			acc(1), acc(2), acc(2), acc(3),
			rd(1'b1, res(2, 0, 0)),            // 3/2 rounds up
			rd(1'b1, res(2, 1, 0)),            // 5/2 tie goes to even
			acc(255),
			rd(1'b1, res(0, 1, 1)),            // wrap clears the count, not the sums
			acc(255), acc(0),                  // one frame over a leftover pixel
			rd(1'b1, res(255, 0, 1)),          // saturates above 255
			rd(1'b1, res(0, 1, 1)),
			cfg(131071),                       // above the limit saturates
			acc(128), acc(127), rd(), rd()
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].si_cfg_unused) set_size(dir_rows[i].size);
			else offer(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
		end

		// frames beyond the limit are dropped
		set_size(1);
		repeat (mfpa_pkg::MAX_FRAMES + 4) offer(mk(mfpa_pkg::OP_ACC, 255));
		offer(mk(mfpa_pkg::OP_READ, 0), 1'b1, res(255, 1, 0));

		// fill the block while the receiver holds off
		set_size(64);
		long_hold_req = 1'b1;
		repeat (3) offer(mk(mfpa_pkg::OP_ACC, $urandom_range(255)));
		repeat (40) offer(mk(mfpa_pkg::OP_READ, $urandom_range(255)));
		drain();

		while (n_items < N_ITEMS - 20) begin
			if (n_items > N_ITEMS - 120) quiet = 1'b1;
			case ($urandom_range(19))
				0:       sz = 0;
				1:       sz = 131071;
				2:       sz = mfpa_pkg::MAX_PIXELS;
				3, 4:    sz = $urandom_range(9, 40);
				default: sz = $urandom_range(1, 8);
			endcase
			set_size(sz);
			if (sz > 40 || $urandom_range(5) == 0) begin
				// noise: random ops, a few dozen at most
				repeat ($urandom_range(4, 30)) begin
					it = mk(1'($urandom_range(1)), $urandom_range(255));
					offer(it);
				end
			end else begin
				if (sz == 0) sz = 1;
				nf = $urandom_range(0, 5);
				repeat (nf * sz + ($urandom_range(3) == 0 ? $urandom_range(sz) : 0))
					offer(mk(mfpa_pkg::OP_ACC, $urandom_range(255)));
				repeat (sz + ($urandom_range(3) == 0 ? $urandom_range(3) : 0))
					offer(mk(mfpa_pkg::OP_READ, $urandom_range(255)));
			end
		end

		drain();
		$display("Sent %0d items over %0d frame sizes, checked %0d averaged pixels.",
			n_items, n_sizes, n_results);
		if (errors == 0)
			$display("multi_frame_pixel_averager_tb: PASS");
		else
			$display("multi_frame_pixel_averager_tb: FAIL");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/mfpa_pkg.sv
sv/mfpa_front.sv
sv/mfpa_queue.sv
sv/mfpa_div.sv
sv/mfpa_back.sv
sv/multi_frame_pixel_averager.sv
bench/multi_frame_pixel_averager_tb.sv
